>>> src/ttgc_pkg.sv
// types and constants shared by the tap tempo gate clock modules
package ttgc_pkg;

	localparam int TIME_W = 32;
	localparam int DEB_W  = 16;
	localparam int DIV_W  = 2;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	// beat division codes
	localparam logic [DIV_W-1:0] DIV_QUARTER = 2'd0;
	localparam logic [DIV_W-1:0] DIV_EIGHTH  = 2'd1;
	localparam logic [DIV_W-1:0] DIV_HALF    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_BEAT_DIVISION = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS   = 1'd1;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              trigger_level;
	} ttgc_in_t;

	typedef struct packed {
		logic              gate;
		logic [TIME_W-1:0] tempo_ms;
	} ttgc_out_t;

	typedef struct packed {
		logic [DIV_W-1:0] beat_division;
		logic [DEB_W-1:0] debounce_ms;
	} ttgc_cfg_t;

endpackage

>>> src/ttgc_core.sv
// gate timer, trigger debounce and tempo state for one poll per cycle while advance is high
module ttgc_core import ttgc_pkg::*; #(
	parameter int INITIAL_TEMPO_MS = 500
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  ttgc_cfg_t cfg,
	input  ttgc_in_t  word,
	output ttgc_out_t result
);

	logic              prev_level_q;
	logic              stable_level_q;
	logic [TIME_W-1:0] deb_start_q;
	logic [TIME_W-1:0] last_tap_q;
	logic [TIME_W-1:0] tempo_q;
	logic [TIME_W-1:0] last_gate_q;

	logic [TIME_W:0]   period;
	logic [TIME_W-1:0] gate_elapsed;
	logic              gate_due;
	logic [TIME_W-1:0] deb_start_d;
	logic [TIME_W-1:0] deb_elapsed;
	logic              level_taken;
	logic              tap;
	logic              gate_d;
	logic [TIME_W-1:0] tempo_d;

	// 33-bit period so that half mode never wraps
	always_comb begin
		case (cfg.beat_division)
			DIV_EIGHTH: period = {2'b00, tempo_q[TIME_W-1:1]};
			DIV_HALF:   period = {tempo_q, 1'b0};
			default:    period = {1'b0, tempo_q};
		endcase
	end

	always_comb begin
		gate_elapsed = word.now_ms - last_gate_q;
		gate_due     = {1'b0, gate_elapsed} >= period;
		deb_start_d  = (word.trigger_level != prev_level_q) ? word.now_ms : deb_start_q;
		deb_elapsed  = word.now_ms - deb_start_d;
		level_taken  = (deb_elapsed >= {{(TIME_W-DEB_W){1'b0}}, cfg.debounce_ms})
			&& (word.trigger_level != stable_level_q);
		tap          = level_taken && word.trigger_level;
		gate_d       = gate_due || tap;
		tempo_d      = tap ? (word.now_ms - last_tap_q) : tempo_q;
		result.gate     = gate_d;
		result.tempo_ms = tempo_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q   <= 1'b0;
			stable_level_q <= 1'b0;
			deb_start_q    <= '0;
			last_tap_q     <= '0;
			tempo_q        <= TIME_W'(INITIAL_TEMPO_MS);
			last_gate_q    <= '0;
		end else if (advance) begin
			prev_level_q <= word.trigger_level;
			deb_start_q  <= deb_start_d;
			tempo_q      <= tempo_d;
			if (level_taken) begin
				stable_level_q <= word.trigger_level;
			end
			if (tap) begin
				last_tap_q <= word.now_ms;
			end
			if (gate_d) begin
				last_gate_q <= word.now_ms;
			end
		end
	end

endmodule

>>> src/tap_tempo_gate_clock_top.sv
// top level of the tap tempo gate clock: handshake, config registers, result register
// an accepted word waits in the input register, then its result is loaded into the output register
// throughput: one word per cycle; one word may wait in the input register behind a stalled result
// the gate timer, debounce and tempo state update in the same cycle the word leaves the input stage
// reset (arst_n low, asynchronous): pipeline empty, tempo = INITIAL_TEMPO_MS, other state zero,
// beat_division quarter, debounce_ms 50
module tap_tempo_gate_clock_top import ttgc_pkg::*; #(
	parameter int INITIAL_TEMPO_MS = 500
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  ttgc_in_t               in_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output ttgc_out_t              out_word,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// config registers
	ttgc_cfg_t cfg_q;

	// input stage
	logic      valid_s1;
	ttgc_in_t  word_s1;

	// result stage
	logic      valid_s2;
	ttgc_out_t word_s2;

	ttgc_out_t result;
	logic      advance;

	// the input stage moves on whenever the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

	// config write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beat_division <= DIV_QUARTER;
			cfg_q.debounce_ms   <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BEAT_DIVISION: cfg_q.beat_division <= cfg_data[DIV_W-1:0];
				CFG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_data[DEB_W-1:0];
			endcase
		end
	end

	// input register: loads whenever it is empty or handing its word on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// per-poll logic and its state
	ttgc_core #(
		.INITIAL_TEMPO_MS(INITIAL_TEMPO_MS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg_q),
		.word    (word_s1),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2 <= result;
		end
	end

endmodule

>>> verif/tb.sv
// testbench for the tap tempo gate clock: queued polls, tempo and gate prediction, result checks
`timescale 1ns / 1ps

module tb;
	import ttgc_pkg::*;

	localparam int INITIAL_TEMPO_MS = 500;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int PHASE_POLLS = 172;
	// code 3 has no name in the package; the block treats it as quarter
	localparam logic [DIV_W-1:0] DIV_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	ttgc_in_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ttgc_out_t out_word;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_BEAT_DIVISION;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tap_tempo_gate_clock_top #(
		.INITIAL_TEMPO_MS(INITIAL_TEMPO_MS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// polls waiting to be driven, and the gate/tempo words they must produce
	ttgc_in_t poll_queue[$];
	ttgc_out_t gate_tempo_due[$];
	int unsigned polls_sent = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count = 0;
	logic no_gaps = 1'b0;
	logic [TIME_W-1:0] clock_ms = '0;

	// register copies, written only while the block is idle
	logic [DIV_W-1:0] div_mode = DIV_QUARTER;
	logic [DEB_W-1:0] hold_ms = DEBOUNCE_RESET;

	// predicted state of the gate timer, debouncer and tap tracker
	logic raw_prev = 1'b0;
	logic level_held = 1'b0;
	logic [TIME_W-1:0] bounce_mark = '0;
	logic [TIME_W-1:0] tap_mark = '0;
	logic [TIME_W-1:0] tempo_now = INITIAL_TEMPO_MS;
	logic [TIME_W-1:0] gate_mark = '0;

	// one poll: gate timer first, then debounce; a debounced rising edge is a tap
	function automatic ttgc_out_t next_gate_tempo(input ttgc_in_t w);
		ttgc_out_t r;
		logic [TIME_W:0] period;
		// period kept at 33 bits so half mode cannot overflow
		case (div_mode)
			DIV_EIGHTH: period = {2'b0, tempo_now[TIME_W-1:1]};
			DIV_HALF: period = {tempo_now, 1'b0};
			default: period = {1'b0, tempo_now};
		endcase
		r.gate = 1'b0;
		if ({1'b0, w.now_ms - gate_mark} >= period) begin
			r.gate = 1'b1;
			gate_mark = w.now_ms;
		end
		// any change of the raw level restarts the debounce window
		if (w.trigger_level != raw_prev)
			bounce_mark = w.now_ms;
		if ((w.now_ms - bounce_mark) >= hold_ms && w.trigger_level != level_held) begin
			level_held = w.trigger_level;
			if (w.trigger_level) begin
				// tap: tempo is the wrapped time since the previous tap, gate fires now
				tempo_now = w.now_ms - tap_mark;
				tap_mark = w.now_ms;
				r.gate = 1'b1;
				gate_mark = w.now_ms;
			end
		end
		raw_prev = w.trigger_level;
		r.tempo_ms = tempo_now;
		return r;
	endfunction

	// driver: predicts each word as it is accepted, then offers the next one or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
		end else begin
			if (in_valid && !in_stall)
				gate_tempo_due.push_back(next_gate_tempo(in_word));
			// a stalled word stays put; otherwise decide on a fresh word or a gap
			if (!in_valid || !in_stall) begin
				if (poll_queue.size() > 0 && (no_gaps || $urandom_range(99) >= 27)) begin
					in_valid <= 1'b1;
					in_word <= poll_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: takes result words, checks them against the oldest prediction, stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin : take_result
			ttgc_out_t due;
			if (out_valid && !out_stall) begin
				if (gate_tempo_due.size() == 0) begin
					$error("result word with nothing expected: gate %0d tempo_ms %0d",
						out_word.gate, out_word.tempo_ms);
					fail_count++;
				end else begin
					due = gate_tempo_due.pop_front();
					results_seen++;
					if (out_word.gate !== due.gate) begin
						$error("gate: expected %0d, actual %0d", due.gate, out_word.gate);
						fail_count++;
					end
					if (out_word.tempo_ms !== due.tempo_ms) begin
						$error("tempo_ms: expected %0d, actual %0d", due.tempo_ms,
							out_word.tempo_ms);
						fail_count++;
					end
				end
			end
			out_stall <= !no_gaps && ($urandom_range(99) < 27);
		end
	end

	// watchdog: too many cycles without any handshake or register write ends the run
	int unsigned quiet_cycles = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	task automatic queue_poll(input logic [TIME_W-1:0] stamp, input logic level);
		ttgc_in_t w;
		w.now_ms = stamp;
		w.trigger_level = level;
		poll_queue.push_back(w);
		polls_sent++;
	endtask

	// wait until every queued poll has its result back, then let the pipeline settle
	task automatic drain();
		while (results_seen != polls_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BEAT_DIVISION)
			div_mode = data[DIV_W-1:0];
		else
			hold_ms = data;
	endtask

	// a press and a release, each after up to three bounce polls, then held to the end of the debounce window
	task automatic queue_tap(input int unsigned hold);
		int unsigned n;
		logic [TIME_W-1:0] edge_ms;
		for (int lvl = 1; lvl >= 0; lvl--) begin
			n = $urandom_range(0, 3);
			repeat (n) begin
				clock_ms += $urandom_range(0, hold / 2 + 1);
				queue_poll(clock_ms, 1'($urandom_range(0, 1)));
			end
			clock_ms += $urandom_range(0, hold / 2 + 1);
			edge_ms = clock_ms;
			queue_poll(clock_ms, lvl[0]);
			n = $urandom_range(0, 2);
			repeat (n) begin
				clock_ms += $urandom_range(0, hold / 4);
				queue_poll(clock_ms, lvl[0]);
			end
			clock_ms = edge_ms + hold + $urandom_range(0, 3);
			queue_poll(clock_ms, lvl[0]);
			// time between taps sets the next tempo
			clock_ms += $urandom_range(0, 1200);
		end
	endtask

	// stray polls: random stamps, stamps going backwards, long quiet spells
	task automatic queue_noise();
		case ($urandom_range(0, 2))
			0: queue_poll($urandom, 1'($urandom_range(0, 1)));
			1: queue_poll(clock_ms - $urandom_range(1, 200), 1'($urandom_range(0, 1)));
			default: begin
				clock_ms += $urandom_range(0, 3000);
				queue_poll(clock_ms, 1'($urandom_range(0, 1)));
			end
		endcase
	endtask

	// stimulus: directed polls, then random phases under changing settings
	logic [DIV_W-1:0] div_plan[PHASES] = '{DIV_QUARTER, DIV_EIGHTH, DIV_HALF, DIV_UNUSED,
		DIV_QUARTER, DIV_EIGHTH, DIV_HALF, DIV_QUARTER};
	logic [DEB_W-1:0] hold_plan[PHASES] = '{16'd50, 16'd0, 16'hFFFF, 16'd1, 16'd300, 16'd20,
		16'hFFFF, 16'd7};

	initial begin
		int unsigned phase_end;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: quarter, 50 ms debounce, tempo 500
		queue_poll(32'd0, 1'b0);     // timer not yet run out
		queue_poll(32'd499, 1'b0);
		queue_poll(32'd500, 1'b0);   // exactly one period
		queue_poll(32'd510, 1'b1);
		queue_poll(32'd530, 1'b0);   // bounce
		queue_poll(32'd540, 1'b1);
		queue_poll(32'd589, 1'b1);   // one ms short of the window
		queue_poll(32'd590, 1'b1);   // first tap, measured from zero
		queue_poll(32'd700, 1'b0);
		queue_poll(32'd760, 1'b0);
		queue_poll(32'hFFFF_FFFF, 1'b1);
		queue_poll(32'd49, 1'b1);    // tap across the wrap
		queue_poll(32'd20, 1'b0);    // time going backwards
		drain();

		// eighth mode with zero debounce: levels taken at once, tempo 1 and then 0
		write_reg(CFG_BEAT_DIVISION, CFG_DATA_W'(DIV_EIGHTH));
		write_reg(CFG_DEBOUNCE_MS, '0);
		queue_poll(32'd1000, 1'b0);
		queue_poll(32'd1001, 1'b1);
		queue_poll(32'd1001, 1'b0);
		queue_poll(32'd1002, 1'b1);  // tempo 1, eighth period 0
		queue_poll(32'd1002, 1'b0);
		queue_poll(32'd1002, 1'b1);  // tempo 0
		drain();

		// unused code acts as quarter; a backwards tap makes tempo all ones
		write_reg(CFG_BEAT_DIVISION, CFG_DATA_W'(DIV_UNUSED));
		queue_poll(32'd1003, 1'b1);
		queue_poll(32'd1003, 1'b0);
		queue_poll(32'd1001, 1'b1);
		drain();

		// half mode on the largest tempo needs the 33rd bit: no gate at all
		write_reg(CFG_BEAT_DIVISION, CFG_DATA_W'(DIV_HALF));
		queue_poll(32'h8000_0000, 1'b1);
		queue_poll(32'd1000, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			// sender holds back until the previous phase is fully answered
			drain();
			write_reg(CFG_BEAT_DIVISION, CFG_DATA_W'(div_plan[p]));
			write_reg(CFG_DEBOUNCE_MS,
				(p == PHASES - 1) ? 16'($urandom_range(0, 2000)) : hold_plan[p]);
			no_gaps = (p == 4);
			if (p == 2)
				clock_ms = 32'hFFFF_8000;
			phase_end = polls_sent + PHASE_POLLS;
			while (polls_sent < phase_end) begin
				if ($urandom_range(99) < 80)
					queue_tap(32'(hold_ms));
				else
					queue_noise();
			end
		end
		no_gaps = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (gate_tempo_due.size() != 0) begin
			$error("%0d expected result words never arrived", gate_tempo_due.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

>>> filelist.f
src/ttgc_pkg.sv
src/ttgc_core.sv
src/tap_tempo_gate_clock_top.sv
verif/tb.sv
